// ===== design/proximity_presence_lock_controller_assert.svh =====
// Assertion macros used by the lock controller sequencer.
`ifndef PROXIMITY_PRESENCE_LOCK_CONTROLLER_ASSERT_SVH
`define PROXIMITY_PRESENCE_LOCK_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PPL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lock controller assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PPL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lock controller assertion failed");

`endif

// ===== design/ppl_pkg.sv =====
package ppl_pkg;

  typedef enum logic [2:0] {
    OP_OBSERVE = 3'd0,
    OP_RADIO   = 3'd1,
    OP_ENABLE  = 3'd2,
    OP_DEV_EN  = 3'd3,
    OP_THRESH  = 3'd4,
    OP_SNOOZE  = 3'd5,
    OP_RESUME  = 3'd6,
    OP_ADVANCE = 3'd7
  } ppl_op_t;

  typedef enum logic [2:0] {
    MODE_DISABLED   = 3'd0,
    MODE_SNOOZED    = 3'd1,
    MODE_STARTING   = 3'd2,
    MODE_ERROR      = 3'd3,
    MODE_MONITORING = 3'd4,
    MODE_AWAITING   = 3'd5,
    MODE_LOCKED     = 3'd6
  } ppl_mode_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_UNKNOWN = 2'd1,
    STS_BAD_SNZ = 2'd2
  } ppl_status_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_SUM, ST_DIV, ST_CMP, ST_CNT, ST_EVAL, ST_ADV, ST_OUT
  } ppl_state_t;

  localparam logic [2:0] REG_AWAY    = 3'd0;
  localparam logic [2:0] REG_SNZ_CAP = 3'd1;
  localparam logic [2:0] REG_GRACE   = 3'd2;
  localparam logic [2:0] REG_MIN_PRS = 3'd3;
  localparam logic [2:0] REG_HYST    = 3'd4;
  localparam logic [2:0] REG_SAMPLES = 3'd5;
  localparam logic [2:0] REG_START   = 3'd6;
  localparam logic [2:0] REG_MASK    = 3'd7;

  localparam logic [15:0] RST_AWAY    = 16'd30;
  localparam logic [15:0] RST_SNZ_CAP = 16'd3600;
  localparam logic [15:0] RST_GRACE   = 16'd10;
  localparam logic [3:0]  RST_MIN_PRS = 4'd1;
  localparam logic [6:0]  RST_HYST    = 7'd5;
  localparam logic [4:0]  RST_SAMPLES = 5'd4;
  localparam logic        RST_START   = 1'b1;
  localparam logic [7:0]  RST_MASK    = 8'd1;

  // Device slots addressable by the 3-bit index and the 8-bit mask.
  localparam int MAX_SLOTS = 8;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [31:0]       now_s;
    logic [2:0]        device_index;
    logic              connected;
    logic              rssi_valid;
    logic signed [7:0] rssi_dbm;
    logic              flag_value;
    logic signed [7:0] threshold_dbm;
    logic [15:0]       snooze_s;
  } ppl_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] machine_mode;
    logic       lock_now;
    logic [3:0] present_count;
  } ppl_out_t;

  typedef struct packed {
    logic [15:0] away_seconds;
    logic [15:0] snooze_cap_seconds;
    logic [15:0] resume_grace_seconds;
    logic [3:0]  min_present;
    logic [6:0]  hysteresis_db;
    logic [4:0]  sample_count;
    logic [7:0]  device_mask;
  } ppl_cfg_t;

  typedef struct packed {
    logic       enable_load;
    logic       enable_value;
    logic       mask_load;
    logic [7:0] mask_value;
  } ppl_cfgwr_t;

  typedef struct packed {
    logic latch;
    logic prep;
    logic sum;
    logic div_load;
    logic div_step;
    logic cmp;
    logic cnt;
    logic eval;
    logic adv;
    logic load;
  } ppl_cmd_t;

  typedef struct packed {
    logic bad;
    logic refresh;
    logic sum_done;
    logic div_done;
    logic cnt_last;
    logic skip_eval;
    logic is_adv;
  } ppl_sts_t;

endpackage

// ===== design/ppl_ctrl.sv =====
module ppl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                request_valid,
  output logic                request_stall,
  input  logic                result_stall,
  output logic                result_valid,
  output ppl_pkg::ppl_cmd_t   cmd,
  input  ppl_pkg::ppl_sts_t   sts
);

  ppl_pkg::ppl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    request_stall = 1'b1;
    case (state)
      ppl_pkg::ST_IDLE: begin
        request_stall = 1'b0;
        if (request_valid) begin
          cmd.latch  = 1'b1;
          state_next = ppl_pkg::ST_PREP;
        end
      end
      ppl_pkg::ST_PREP: begin
        cmd.prep = 1'b1;
        if (!sts.bad && sts.refresh) begin
          state_next = ppl_pkg::ST_SUM;
        end else begin
          state_next = ppl_pkg::ST_CNT;
        end
      end
      ppl_pkg::ST_SUM: begin
        cmd.sum = 1'b1;
        if (sts.sum_done) begin
          cmd.div_load = 1'b1;
          state_next   = ppl_pkg::ST_DIV;
        end
      end
      ppl_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = ppl_pkg::ST_CMP;
        end
      end
      ppl_pkg::ST_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = ppl_pkg::ST_CNT;
      end
      ppl_pkg::ST_CNT: begin
        cmd.cnt = 1'b1;
        if (sts.cnt_last) begin
          state_next = sts.skip_eval ? ppl_pkg::ST_OUT : ppl_pkg::ST_EVAL;
        end
      end
      ppl_pkg::ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.is_adv ? ppl_pkg::ST_ADV : ppl_pkg::ST_OUT;
      end
      ppl_pkg::ST_ADV: begin
        cmd.adv    = 1'b1;
        state_next = ppl_pkg::ST_OUT;
      end
      ppl_pkg::ST_OUT: begin
        if (!result_valid || !result_stall) begin
          cmd.load   = 1'b1;
          state_next = ppl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ppl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

`include "proximity_presence_lock_controller_assert.svh"

  `PPL_ASSERT_IMP(a_busy_stalls, clk, rst, state != ppl_pkg::ST_IDLE, request_stall)
  `PPL_ASSERT_NXT(a_accept_prep, clk, rst, request_valid && !request_stall, state == ppl_pkg::ST_PREP)
  `PPL_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.load, !result_valid || !result_stall)
  `PPL_ASSERT_NXT(a_load_shows, clk, rst, cmd.load, result_valid && state == ppl_pkg::ST_IDLE)

endmodule

// ===== design/ppl_dpath.sv =====
module ppl_dpath #(
  parameter int DEVICES = 8,
  parameter int WINDOW  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ppl_pkg::ppl_in_t    request,
  input  ppl_pkg::ppl_cfg_t   cfg,
  input  ppl_pkg::ppl_cfgwr_t cfgwr,
  input  ppl_pkg::ppl_cmd_t   cmd,
  output ppl_pkg::ppl_sts_t   sts,
  output ppl_pkg::ppl_out_t   result
);

  localparam int IW   = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int SW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW   = $clog2(WINDOW + 1);
  localparam int SUMW = 8 + FW;
  localparam int NCHK = (DEVICES < ppl_pkg::MAX_SLOTS) ? DEVICES : ppl_pkg::MAX_SLOTS;
  localparam int CW   = $clog2(SUMW + 1);

  ppl_pkg::ppl_in_t it;

  logic                 dev_en   [DEVICES];
  logic                 thr_v    [DEVICES];
  logic signed [7:0]    thr      [DEVICES];
  logic                 obs      [DEVICES];
  logic                 conn     [DEVICES];
  logic                 fv       [DEVICES];
  logic                 fl       [DEVICES];
  logic [FW-1:0]        fill     [DEVICES];
  logic [SW-1:0]        head     [DEVICES];
  logic signed [7:0]    win      [DEVICES][WINDOW];

  logic                 gen, radio, seen;
  ppl_pkg::ppl_mode_t   mode;
  logic                 away_v, snz_v, grc_v;
  logic [31:0]          away_s, snz_u, grc_u;
  ppl_pkg::ppl_status_t status_r;
  logic                 lock_r;

  logic [FW-1:0]        k;
  logic                 pend;
  logic signed [7:0]    rdata;
  logic signed [SUMW-1:0] sum;
  logic [SUMW-1:0]      quo;
  logic [FW-1:0]        rem;
  logic                 neg;
  logic [CW-1:0]        dcnt;
  logic [IW-1:0]        cidx;
  logic [3:0]           ccount;

  logic [IW-1:0]        dsel;
  logic                 dev_ok;
  ppl_pkg::ppl_status_t status_c;
  logic [FW-1:0]        n_eff, nfill;
  logic [FW:0]          tmp_h, tmp_w, tmp_r;
  logic [SW-1:0]        nhead, wslot, rslot;
  logic                 push;
  logic [FW:0]          trial;
  logic signed [9:0]    avg, cut;
  logic                 pres;
  logic [32:0]          snz_sum, grc_sum;
  logic [31:0]          away_el;

  function automatic logic cfgd(input int i, input logic [7:0] mask);
    if (i < ppl_pkg::MAX_SLOTS) begin
      return mask[i];
    end
    return 1'b0;
  endfunction

  assign dsel   = IW'(it.device_index);
  assign dev_ok = (32'(it.device_index) < DEVICES) && cfg.device_mask[it.device_index];

  always_comb begin
    status_c = ppl_pkg::STS_OK;
    case (ppl_pkg::ppl_op_t'(it.cmd))
      ppl_pkg::OP_OBSERVE, ppl_pkg::OP_DEV_EN, ppl_pkg::OP_THRESH: begin
        if (!dev_ok) status_c = ppl_pkg::STS_UNKNOWN;
      end
      ppl_pkg::OP_SNOOZE: begin
        if (it.snooze_s == 16'd0 || it.snooze_s > cfg.snooze_cap_seconds) begin
          status_c = ppl_pkg::STS_BAD_SNZ;
        end
      end
      default: status_c = ppl_pkg::STS_OK;
    endcase
  end

  // Window push: trim the oldest samples down to one below the count, then append; also the read slot for the sum.
  always_comb begin
    if (cfg.sample_count == 5'd0) begin
      n_eff = FW'(1);
    end else if (32'(cfg.sample_count) > WINDOW) begin
      n_eff = FW'(WINDOW);
    end else begin
      n_eff = FW'(cfg.sample_count);
    end
    if (fill[dsel] >= n_eff) begin
      tmp_h = (FW+1)'(head[dsel]) + (FW+1)'(fill[dsel] - n_eff) + (FW+1)'(1);
      nfill = n_eff - FW'(1);
    end else begin
      tmp_h = (FW+1)'(head[dsel]);
      nfill = fill[dsel];
    end
    if (32'(tmp_h) >= WINDOW) tmp_h = tmp_h - (FW+1)'(WINDOW);
    nhead = SW'(tmp_h);
    tmp_w = (FW+1)'(nhead) + (FW+1)'(nfill);
    if (32'(tmp_w) >= WINDOW) tmp_w = tmp_w - (FW+1)'(WINDOW);
    wslot = SW'(tmp_w);
    tmp_r = (FW+1)'(head[dsel]) + (FW+1)'(k);
    if (32'(tmp_r) >= WINDOW) tmp_r = tmp_r - (FW+1)'(WINDOW);
    rslot = SW'(tmp_r);
  end

  assign push = cmd.prep && (ppl_pkg::ppl_op_t'(it.cmd) == ppl_pkg::OP_OBSERVE) && dev_ok
                && it.rssi_valid && thr_v[dsel];

  always_ff @(posedge clk) begin
    if (push) begin
      win[dsel][wslot] <= it.rssi_dbm;
    end
    if (cmd.sum && k < fill[dsel]) begin
      rdata <= win[dsel][rslot];
    end
  end

  assign trial = {rem, quo[SUMW-1]} - (FW+1)'(fill[dsel]);
  assign avg   = neg ? -$signed(10'(quo)) : $signed(10'(quo));
  assign cut   = 10'(thr[dsel]) - ((fv[dsel] && fl[dsel]) ? $signed(10'(cfg.hysteresis_db))
                                                          : 10'sd0);
  assign pres  = cfgd(32'(cidx), cfg.device_mask) && dev_en[cidx] && obs[cidx]
                 && (fv[cidx] ? fl[cidx] : conn[cidx]);
  assign snz_sum = 33'(it.now_s) + 33'(it.snooze_s);
  assign grc_sum = 33'(it.now_s) + 33'(cfg.resume_grace_seconds);
  assign away_el = it.now_s - away_s;

  always_ff @(posedge clk) begin
    if (cmd.latch) it <= request;
    if (cmd.div_load) begin
      neg  <= sum < 0;
      quo  <= (sum < 0) ? SUMW'(-sum) : SUMW'(sum);
      rem  <= '0;
    end else if (cmd.div_step) begin
      if (!trial[FW]) begin
        rem <= FW'(trial);
        quo <= {quo[SUMW-2:0], 1'b1};
      end else begin
        rem <= FW'({rem, quo[SUMW-1]});
        quo <= {quo[SUMW-2:0], 1'b0};
      end
    end
    if (cmd.load) begin
      result.status        <= status_r;
      result.machine_mode  <= mode;
      result.lock_now      <= lock_r;
      result.present_count <= ccount;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEVICES; i++) begin
        dev_en[i] <= cfgd(i, ppl_pkg::RST_MASK);
        thr_v[i]  <= 1'b0;
        thr[i]    <= '0;
        obs[i]    <= 1'b0;
        conn[i]   <= 1'b0;
        fv[i]     <= 1'b0;
        fl[i]     <= 1'b0;
        fill[i]   <= '0;
        head[i]   <= '0;
      end
      gen      <= ppl_pkg::RST_START;
      radio    <= 1'b0;
      seen     <= 1'b0;
      mode     <= ppl_pkg::MODE_STARTING;
      away_v   <= 1'b0;
      snz_v    <= 1'b0;
      grc_v    <= 1'b0;
      away_s   <= '0;
      snz_u    <= '0;
      grc_u    <= '0;
      status_r <= ppl_pkg::STS_OK;
      lock_r   <= 1'b0;
      k        <= '0;
      pend     <= 1'b0;
      sum      <= '0;
      dcnt     <= '0;
      cidx     <= '0;
      ccount   <= '0;
    end else begin
      if (cfgwr.enable_load) gen <= cfgwr.enable_value;
      if (cfgwr.mask_load) begin
        for (int i = 0; i < DEVICES; i++) dev_en[i] <= cfgd(i, cfgwr.mask_value);
      end
      if (cmd.prep) begin
        status_r <= status_c;
        lock_r   <= 1'b0;
        k        <= '0;
        pend     <= 1'b0;
        sum      <= '0;
        cidx     <= '0;
        ccount   <= '0;
        if (status_c == ppl_pkg::STS_OK) begin
          case (ppl_pkg::ppl_op_t'(it.cmd))
            ppl_pkg::OP_OBSERVE: begin
              obs[dsel]  <= 1'b1;
              conn[dsel] <= it.connected;
              seen       <= 1'b1;
              if (push) begin
                head[dsel] <= nhead;
                fill[dsel] <= nfill + FW'(1);
              end else begin
                head[dsel] <= '0;
                fill[dsel] <= '0;
                fv[dsel]   <= 1'b0;
                fl[dsel]   <= 1'b0;
              end
            end
            ppl_pkg::OP_RADIO:  radio <= it.flag_value;
            ppl_pkg::OP_ENABLE: gen   <= it.flag_value;
            ppl_pkg::OP_DEV_EN: dev_en[dsel] <= it.flag_value;
            ppl_pkg::OP_THRESH: begin
              thr[dsel]   <= it.threshold_dbm;
              thr_v[dsel] <= 1'b1;
              if (fill[dsel] == '0) begin
                fv[dsel] <= 1'b0;
                fl[dsel] <= 1'b0;
              end
            end
            ppl_pkg::OP_SNOOZE: begin
              snz_u <= snz_sum[32] ? 32'hFFFF_FFFF : snz_sum[31:0];
              snz_v <= 1'b1;
            end
            ppl_pkg::OP_RESUME: begin
              grc_u <= grc_sum[32] ? 32'hFFFF_FFFF : grc_sum[31:0];
              grc_v <= 1'b1;
            end
            default: ;
          endcase
        end
      end
      if (cmd.sum) begin
        pend <= k < fill[dsel];
        if (k < fill[dsel]) k <= k + FW'(1);
        if (pend) sum <= sum + SUMW'(rdata);
      end
      if (cmd.div_load) begin
        dcnt <= CW'(SUMW);
      end else if (cmd.div_step) begin
        dcnt <= dcnt - CW'(1);
      end
      if (cmd.cmp) begin
        fl[dsel] <= avg >= cut;
        fv[dsel] <= 1'b1;
      end
      if (cmd.cnt) begin
        ccount <= ccount + 4'(pres);
        cidx   <= cidx + IW'(1);
      end
      if (cmd.eval) begin
        if (!gen) begin
          away_v <= 1'b0;
          snz_v  <= 1'b0;
          mode   <= ppl_pkg::MODE_DISABLED;
        end else if (snz_v && it.now_s < snz_u) begin
          mode <= ppl_pkg::MODE_SNOOZED;
        end else begin
          snz_v <= 1'b0;
          if (grc_v && it.now_s < grc_u) begin
            mode <= ppl_pkg::MODE_STARTING;
          end else begin
            grc_v <= 1'b0;
            if (!seen) begin
              mode <= radio ? ppl_pkg::MODE_STARTING : ppl_pkg::MODE_ERROR;
            end else if (radio && ccount >= cfg.min_present) begin
              away_v <= 1'b0;
              mode   <= ppl_pkg::MODE_MONITORING;
            end else begin
              if (!away_v) begin
                away_v <= 1'b1;
                away_s <= it.now_s;
              end
              mode <= radio ? ppl_pkg::MODE_AWAITING : ppl_pkg::MODE_ERROR;
            end
          end
        end
      end
      if (cmd.adv) begin
        if (mode != ppl_pkg::MODE_SNOOZED && mode != ppl_pkg::MODE_STARTING && away_v
            && it.now_s >= away_s && away_el >= 32'(cfg.away_seconds)) begin
          mode   <= ppl_pkg::MODE_LOCKED;
          away_v <= 1'b0;
          lock_r <= 1'b1;
        end
      end
    end
  end

  assign sts.bad       = status_c != ppl_pkg::STS_OK;
  assign sts.refresh   = push || ((ppl_pkg::ppl_op_t'(it.cmd) == ppl_pkg::OP_THRESH)
                                  && fill[dsel] != '0);
  assign sts.sum_done  = (k == fill[dsel]) && !pend;
  assign sts.div_done  = dcnt == CW'(1);
  assign sts.cnt_last  = 32'(cidx) == NCHK - 1;
  assign sts.skip_eval = status_r != ppl_pkg::STS_OK;
  assign sts.is_adv    = ppl_pkg::ppl_op_t'(it.cmd) == ppl_pkg::OP_ADVANCE;

endmodule

// ===== design/proximity_presence_lock_controller.sv =====
// An event is latched and checked, then its device window is summed and divided serially
// when a window refresh is needed, the devices are counted, the mode is evaluated unless
// the event was refused, and an advance adds its lock check before the result is loaded.
// The block takes one event at a time; the window sum, the serial divider and the device
// count scan keep it busy. A finished result waits in its register while the next
// event is taken. Reset is synchronous; the sample memory, divider, latched event and result are not reset.
module proximity_presence_lock_controller #(
  parameter int DEVICES = 8,
  parameter int WINDOW  = 16
) (
  input  logic              clk,
  input  logic              rst,
  // Event channel.
  input  logic              request_valid,
  output logic              request_stall,
  input  ppl_pkg::ppl_in_t  request,
  // Result channel.
  output logic              result_valid,
  input  logic              result_stall,
  output ppl_pkg::ppl_out_t result,
  // Register port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers. Register i sits at byte address 4*i.
  ppl_pkg::ppl_cfg_t   cfg;
  logic                start_enabled;
  ppl_pkg::ppl_cfgwr_t cfgwr;
  ppl_pkg::ppl_cmd_t   cmd;
  ppl_pkg::ppl_sts_t   sts;
  logic                wr;
  logic [2:0]          idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.away_seconds         <= ppl_pkg::RST_AWAY;
      cfg.snooze_cap_seconds   <= ppl_pkg::RST_SNZ_CAP;
      cfg.resume_grace_seconds <= ppl_pkg::RST_GRACE;
      cfg.min_present          <= ppl_pkg::RST_MIN_PRS;
      cfg.hysteresis_db        <= ppl_pkg::RST_HYST;
      cfg.sample_count         <= ppl_pkg::RST_SAMPLES;
      cfg.device_mask          <= ppl_pkg::RST_MASK;
      start_enabled            <= ppl_pkg::RST_START;
    end else if (wr) begin
      case (idx)
        ppl_pkg::REG_AWAY:    cfg.away_seconds         <= pwdata[15:0];
        ppl_pkg::REG_SNZ_CAP: cfg.snooze_cap_seconds   <= pwdata[15:0];
        ppl_pkg::REG_GRACE:   cfg.resume_grace_seconds <= pwdata[15:0];
        ppl_pkg::REG_MIN_PRS: cfg.min_present          <= pwdata[3:0];
        ppl_pkg::REG_HYST:    cfg.hysteresis_db        <= pwdata[6:0];
        ppl_pkg::REG_SAMPLES: cfg.sample_count         <= pwdata[4:0];
        ppl_pkg::REG_START:   start_enabled            <= pwdata[0];
        ppl_pkg::REG_MASK:    cfg.device_mask          <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Writing the start enable also loads the global enable; writing the mask
  // reloads every device enable from its mask bit.
  assign cfgwr.enable_load  = wr && idx == ppl_pkg::REG_START;
  assign cfgwr.enable_value = pwdata[0];
  assign cfgwr.mask_load    = wr && idx == ppl_pkg::REG_MASK;
  assign cfgwr.mask_value   = pwdata[7:0];

  always_comb begin
    case (idx)
      ppl_pkg::REG_AWAY:    prdata = 32'(cfg.away_seconds);
      ppl_pkg::REG_SNZ_CAP: prdata = 32'(cfg.snooze_cap_seconds);
      ppl_pkg::REG_GRACE:   prdata = 32'(cfg.resume_grace_seconds);
      ppl_pkg::REG_MIN_PRS: prdata = 32'(cfg.min_present);
      ppl_pkg::REG_HYST:    prdata = 32'(cfg.hysteresis_db);
      ppl_pkg::REG_SAMPLES: prdata = 32'(cfg.sample_count);
      ppl_pkg::REG_START:   prdata = 32'(start_enabled);
      ppl_pkg::REG_MASK:    prdata = 32'(cfg.device_mask);
      default:              prdata = '0;
    endcase
  end

  // The sequencer steps each event through its phases; the datapath holds the
  // device state, the sample memory, the divider and the mode logic.
  ppl_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .result_stall  (result_stall),
    .result_valid  (result_valid),
    .cmd           (cmd),
    .sts           (sts)
  );

  ppl_dpath #(
    .DEVICES (DEVICES),
    .WINDOW  (WINDOW)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cfg     (cfg),
    .cfgwr   (cfgwr),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result)
  );

endmodule

// ===== verif/tb_proximity_presence_lock_controller.sv =====
`timescale 1ns / 100ps

// Lock controller testbench.
// Timestamped events are sent through the event channel and each result is
// compared with a behavioural prediction that the scoreboard keeps in step
// with every accepted transfer. Registers are written over the register
// port only while the block is quiet, and the run passes through several
// register settings, the extremes among them.
module tb_proximity_presence_lock_controller;

  localparam int NDEV = 8;
  localparam int WIN = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  // Scoreboard: holds its own copy of the controller state and a queue of
  // predicted results, one per accepted event.
  class lock_scoreboard;
    logic [15:0] away_s, snz_cap, grace_s;
    logic [3:0] min_prs;
    logic [6:0] hyst;
    logic [4:0] samples;
    logic start_en;
    logic [7:0] mask;
    bit g_en, radio, seen, away_v, snz_v, grace_v;
    ppl_pkg::ppl_mode_t mode;
    logic [31:0] away_t, snz_t, grace_t;
    bit en[NDEV], thr_v[NDEV], obs[NDEV], conn[NDEV], flag_v[NDEV], flag[NDEV];
    int thr[NDEV];
    int win[NDEV][WIN];
    int fill[NDEV], head[NDEV];
    ppl_pkg::ppl_out_t pending[$];
    int mismatches;

    function void reset_state();
      away_s = ppl_pkg::RST_AWAY; snz_cap = ppl_pkg::RST_SNZ_CAP;
      grace_s = ppl_pkg::RST_GRACE;
      min_prs = ppl_pkg::RST_MIN_PRS; hyst = ppl_pkg::RST_HYST;
      samples = ppl_pkg::RST_SAMPLES;
      start_en = ppl_pkg::RST_START; mask = ppl_pkg::RST_MASK;
      g_en = start_en; radio = 0; seen = 0; away_v = 0; snz_v = 0; grace_v = 0;
      mode = ppl_pkg::MODE_STARTING; away_t = 0; snz_t = 0; grace_t = 0;
      for (int i = 0; i < NDEV; i++) begin
        en[i] = mask[i]; thr_v[i] = 0; obs[i] = 0; conn[i] = 0;
        flag_v[i] = 0; flag[i] = 0; thr[i] = 0; fill[i] = 0; head[i] = 0;
      end
      pending.delete();
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        ppl_pkg::REG_AWAY: away_s = v[15:0];
        ppl_pkg::REG_SNZ_CAP: snz_cap = v[15:0];
        ppl_pkg::REG_GRACE: grace_s = v[15:0];
        ppl_pkg::REG_MIN_PRS: min_prs = v[3:0];
        ppl_pkg::REG_HYST: hyst = v[6:0];
        ppl_pkg::REG_SAMPLES: samples = v[4:0];
        ppl_pkg::REG_START: begin
          start_en = v[0];
          g_en = v[0];
        end
        ppl_pkg::REG_MASK: begin
          mask = v[7:0];
          for (int i = 0; i < NDEV; i++) en[i] = mask[i];
        end
        default: ;
      endcase
    endfunction

    function int present_devices();
      int n;
      n = 0;
      for (int i = 0; i < NDEV; i++)
        if (mask[i] && en[i] && obs[i] && (flag_v[i] ? flag[i] : conn[i])) n++;
      return n;
    endfunction

    function void refresh(int d);
      int sum, avg, cut;
      if (!thr_v[d] || fill[d] == 0) begin
        flag_v[d] = 0; flag[d] = 0;
        return;
      end
      sum = 0;
      for (int k = 0; k < fill[d]; k++) sum += win[d][(head[d] + k) % WIN];
      avg = sum / fill[d];
      cut = thr[d];
      if (flag_v[d] && flag[d]) cut -= int'(hyst);
      flag[d] = avg >= cut;
      flag_v[d] = 1;
    endfunction

    function void push_sample(int d, int v);
      int n;
      n = int'(samples);
      if (n < 1) n = 1;
      if (n > WIN) n = WIN;
      while (fill[d] >= n) begin
        head[d] = (head[d] + 1) % WIN;
        fill[d]--;
      end
      win[d][(head[d] + fill[d]) % WIN] = v;
      fill[d]++;
    endfunction

    function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function void settle(logic [31:0] now);
      if (!g_en) begin
        away_v = 0; snz_v = 0; mode = ppl_pkg::MODE_DISABLED;
        return;
      end
      if (snz_v && now < snz_t) begin
        mode = ppl_pkg::MODE_SNOOZED;
        return;
      end
      snz_v = 0;
      if (grace_v && now < grace_t) begin
        mode = ppl_pkg::MODE_STARTING;
        return;
      end
      grace_v = 0;
      if (!seen) begin
        mode = radio ? ppl_pkg::MODE_STARTING : ppl_pkg::MODE_ERROR;
        return;
      end
      if (radio && present_devices() >= int'(min_prs)) begin
        away_v = 0; mode = ppl_pkg::MODE_MONITORING;
        return;
      end
      if (!away_v) begin
        away_v = 1; away_t = now;
      end
      mode = radio ? ppl_pkg::MODE_AWAITING : ppl_pkg::MODE_ERROR;
    endfunction

    // Works out the result of one accepted event and queues it.
    function void note_event(ppl_pkg::ppl_in_t ev);
      ppl_pkg::ppl_out_t r;
      int d;
      ppl_pkg::ppl_status_t sts;
      bit lock;
      d = int'(ev.device_index);
      sts = ppl_pkg::STS_OK;
      lock = 0;
      case (ppl_pkg::ppl_op_t'(ev.cmd))
        ppl_pkg::OP_OBSERVE: begin
          if (!mask[d]) sts = ppl_pkg::STS_UNKNOWN;
          else begin
            obs[d] = 1; conn[d] = ev.connected; seen = 1;
            if (!ev.rssi_valid || !thr_v[d]) begin
              fill[d] = 0; head[d] = 0; flag_v[d] = 0; flag[d] = 0;
            end else begin
              push_sample(d, int'(ev.rssi_dbm));
              refresh(d);
            end
            settle(ev.now_s);
          end
        end
        ppl_pkg::OP_RADIO: begin
          radio = ev.flag_value;
          settle(ev.now_s);
        end
        ppl_pkg::OP_ENABLE: begin
          g_en = ev.flag_value;
          settle(ev.now_s);
        end
        ppl_pkg::OP_DEV_EN: begin
          if (!mask[d]) sts = ppl_pkg::STS_UNKNOWN;
          else begin
            en[d] = ev.flag_value;
            settle(ev.now_s);
          end
        end
        ppl_pkg::OP_THRESH: begin
          if (!mask[d]) sts = ppl_pkg::STS_UNKNOWN;
          else begin
            thr[d] = int'(ev.threshold_dbm); thr_v[d] = 1;
            refresh(d);
            settle(ev.now_s);
          end
        end
        ppl_pkg::OP_SNOOZE: begin
          if (ev.snooze_s == 0 || ev.snooze_s > snz_cap) sts = ppl_pkg::STS_BAD_SNZ;
          else begin
            snz_t = sat_add(ev.now_s, 32'(ev.snooze_s)); snz_v = 1;
            settle(ev.now_s);
          end
        end
        ppl_pkg::OP_RESUME: begin
          grace_t = sat_add(ev.now_s, 32'(grace_s)); grace_v = 1;
          settle(ev.now_s);
        end
        default: begin
          settle(ev.now_s);
          if (mode != ppl_pkg::MODE_SNOOZED && mode != ppl_pkg::MODE_STARTING && away_v &&
              ev.now_s >= away_t &&
              (64'(ev.now_s) - 64'(away_t)) >= 64'(away_s)) begin
            mode = ppl_pkg::MODE_LOCKED; away_v = 0; lock = 1;
          end
        end
      endcase
      r.status = sts;
      r.machine_mode = mode;
      r.lock_now = lock;
      r.present_count = 4'(present_devices());
      pending = {pending, r};
    endfunction

    function void check_result(ppl_pkg::ppl_out_t got);
      ppl_pkg::ppl_out_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing predicted: %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status || got.machine_mode !== exp_r.machine_mode ||
          got.lock_now !== exp_r.lock_now || got.present_count !== exp_r.present_count)
      begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: status %0d/%0d mode %0d/%0d lock %0d/%0d count %0d/%0d",
                   exp_r.status, got.status, exp_r.machine_mode, got.machine_mode,
                   exp_r.lock_now, got.lock_now, exp_r.present_count,
                   got.present_count);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic request_valid = 1'b0;
  logic request_stall;
  ppl_pkg::ppl_in_t request = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  ppl_pkg::ppl_out_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lock_scoreboard lock_sb;
  int idle_cycles;
  logic [31:0] clock_s;
  bit sink_quiet;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  proximity_presence_lock_controller u_dut (
    .clk(clk), .rst(rst),
    .request_valid(request_valid), .request_stall(request_stall), .request(request),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Most gaps are short; now and then a long one.
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side: the stall is changed at random, and every transfer is
  // checked at the edge where it happens.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) lock_sb.check_result(result);
      if (sink_quiet) result_stall <= 1'b0;
      else result_stall <= ($urandom_range(0, 99) < 30);
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if (rst || (request_valid && !request_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_proximity_presence_lock_controller: errors");
        $finish;
      end
    end
  end

  // Valid is dropped at the start of a gap, or replaced at once by the next
  // event when there is none; drain() drops it after the last event.
  task automatic send_event(ppl_pkg::ppl_in_t ev);
    int gap;
    gap = gap_length();
    if (gap != 0) begin
      request_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request <= ev;
    request_valid <= 1'b1;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    lock_sb.note_event(ev);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    lock_sb.write_reg(idx, v);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Waits for every predicted result, then a margin past the longest latency.
  task automatic drain();
    request_valid <= 1'b0;
    while (lock_sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_op(ppl_pkg::ppl_op_t op, int d, logic [7:0] val, logic [15:0] snz);
    ppl_pkg::ppl_in_t ev;
    ev = '0;
    ev.cmd = op;
    ev.now_s = clock_s;
    ev.device_index = 3'(d);
    ev.connected = val[0];
    ev.rssi_valid = 1'b1;
    ev.rssi_dbm = val;
    ev.flag_value = val[0];
    ev.threshold_dbm = val;
    ev.snooze_s = snz;
    send_event(ev);
  endtask

  // A random event. Time mostly moves forward in small steps, sometimes in
  // large ones, occasionally backwards, and now and then to a random value.
  task automatic random_event(logic [7:0] dev_set);
    ppl_pkg::ppl_in_t ev;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) clock_s = clock_s + $urandom_range(0, 15);
    else if (roll < 90) clock_s = clock_s + $urandom_range(0, 5000);
    else if (roll < 95) clock_s = clock_s - $urandom_range(0, 20);
    else clock_s = $urandom();
    ev.now_s = clock_s;
    ev.device_index = 3'($urandom_range(0, 7));
    while (dev_set != 0 && !dev_set[ev.device_index] && $urandom_range(0, 3) != 0)
      ev.device_index = 3'($urandom_range(0, 7));
    roll = $urandom_range(0, 99);
    if (roll < 45) ev.cmd = ppl_pkg::OP_OBSERVE;
    else if (roll < 52) ev.cmd = ppl_pkg::OP_RADIO;
    else if (roll < 56) ev.cmd = ppl_pkg::OP_ENABLE;
    else if (roll < 62) ev.cmd = ppl_pkg::OP_DEV_EN;
    else if (roll < 70) ev.cmd = ppl_pkg::OP_THRESH;
    else if (roll < 75) ev.cmd = ppl_pkg::OP_SNOOZE;
    else if (roll < 80) ev.cmd = ppl_pkg::OP_RESUME;
    else ev.cmd = ppl_pkg::OP_ADVANCE;
    ev.connected = 1'($urandom_range(0, 1));
    ev.rssi_valid = ($urandom_range(0, 9) < 8);
    ev.rssi_dbm = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
                  8'(-$urandom_range(40, 90));
    ev.flag_value = ($urandom_range(0, 9) < 7);
    ev.threshold_dbm = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
                       8'(-$urandom_range(50, 80));
    ev.snooze_s = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535)) :
                  16'($urandom_range(0, 40));
    send_event(ev);
  endtask

  initial begin
    lock_sb = new();
    lock_sb.reset_state();
    clock_s = 32'd100;
    sink_quiet = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the reset settings: error before any radio, unknown
    // device, bad snooze durations, presence by threshold, lock on advance.
    send_op(ppl_pkg::OP_ADVANCE, 0, 8'd0, 16'd0);
    send_op(ppl_pkg::OP_OBSERVE, 3, 8'd1, 16'd0);
    send_op(ppl_pkg::OP_RADIO, 0, 8'd1, 16'd0);
    send_op(ppl_pkg::OP_THRESH, 0, 8'h80, 16'd0);
    send_op(ppl_pkg::OP_OBSERVE, 0, 8'h7F, 16'd0);
    send_op(ppl_pkg::OP_THRESH, 0, 8'h7F, 16'd0);
    send_op(ppl_pkg::OP_OBSERVE, 0, 8'h80, 16'd0);
    clock_s = clock_s + 30;
    send_op(ppl_pkg::OP_ADVANCE, 0, 8'd0, 16'd0);
    send_op(ppl_pkg::OP_SNOOZE, 0, 8'd0, 16'd0);
    send_op(ppl_pkg::OP_SNOOZE, 0, 8'd0, 16'd3601);
    send_op(ppl_pkg::OP_SNOOZE, 0, 8'd0, 16'd3600);
    send_op(ppl_pkg::OP_ADVANCE, 0, 8'd0, 16'd0);
    send_op(ppl_pkg::OP_RESUME, 0, 8'd0, 16'd0);
    send_op(ppl_pkg::OP_DEV_EN, 5, 8'd0, 16'd0);
    send_op(ppl_pkg::OP_DEV_EN, 0, 8'd0, 16'd0);
    send_op(ppl_pkg::OP_ENABLE, 0, 8'd0, 16'd0);
    send_op(ppl_pkg::OP_ENABLE, 0, 8'd1, 16'd0);
    clock_s = 32'hFFFF_FFF0;
    send_op(ppl_pkg::OP_SNOOZE, 0, 8'd0, 16'd100);
    send_op(ppl_pkg::OP_RESUME, 0, 8'd0, 16'd0);
    clock_s = 32'hFFFF_FFFF;
    send_op(ppl_pkg::OP_ADVANCE, 0, 8'd0, 16'd0);
    clock_s = 32'd5;
    send_op(ppl_pkg::OP_ADVANCE, 0, 8'd0, 16'd0);
    drain();

    // Several register settings, each followed by random traffic. The
    // first two cover the extremes of every register.
    for (int phase = 0; phase < 5; phase++) begin
      logic [7:0] devs;
      case (phase)
        0: begin
          reg_write(ppl_pkg::REG_AWAY, 32'd0); reg_write(ppl_pkg::REG_SNZ_CAP, 32'd1);
          reg_write(ppl_pkg::REG_GRACE, 32'd0); reg_write(ppl_pkg::REG_MIN_PRS, 32'd0);
          reg_write(ppl_pkg::REG_HYST, 32'd0); reg_write(ppl_pkg::REG_SAMPLES, 32'd0);
          reg_write(ppl_pkg::REG_START, 32'd0); reg_write(ppl_pkg::REG_MASK, 32'hFF);
        end
        1: begin
          reg_write(ppl_pkg::REG_AWAY, 32'd65535);
          reg_write(ppl_pkg::REG_SNZ_CAP, 32'd65535);
          reg_write(ppl_pkg::REG_GRACE, 32'd65535);
          reg_write(ppl_pkg::REG_MIN_PRS, 32'd15);
          reg_write(ppl_pkg::REG_HYST, 32'd127); reg_write(ppl_pkg::REG_SAMPLES, 32'd31);
          reg_write(ppl_pkg::REG_START, 32'd1); reg_write(ppl_pkg::REG_MASK, 32'h00);
        end
        default: begin
          reg_write(ppl_pkg::REG_AWAY, $urandom_range(0, 40));
          reg_write(ppl_pkg::REG_SNZ_CAP, $urandom_range(1, 30));
          reg_write(ppl_pkg::REG_GRACE, $urandom_range(0, 20));
          reg_write(ppl_pkg::REG_MIN_PRS, $urandom_range(1, 3));
          reg_write(ppl_pkg::REG_HYST, $urandom_range(0, 64));
          reg_write(ppl_pkg::REG_SAMPLES, $urandom_range(1, 16));
          reg_write(ppl_pkg::REG_START, $urandom_range(0, 1));
          reg_write(ppl_pkg::REG_MASK, $urandom_range(0, 255) | 32'h01);
        end
      endcase
      devs = lock_sb.mask;
      // The global enable is switched on early so the monitoring logic is reached.
      send_op(ppl_pkg::OP_ENABLE, 0, 8'd1, 16'd0);
      send_op(ppl_pkg::OP_RADIO, 0, 8'd1, 16'd0);
      for (int n = 0; n < 160; n++) begin
        // A shorter window mid-phase exercises trimming at the next sample.
        if (n == 80 && phase >= 2) begin
          drain();
          reg_write(ppl_pkg::REG_SAMPLES, $urandom_range(0, 3));
        end
        random_event(devs);
      end
      drain();
    end

    sink_quiet = 1'b1;
    drain();
    if (lock_sb.mismatches == 0 && lock_sb.pending.size() == 0)
      $display("tb_proximity_presence_lock_controller: clean");
    else
      $display("tb_proximity_presence_lock_controller: errors");
    $finish;
  end
endmodule
